@@ sv/gne_pkg.sv @@
// Shared types, command codes and controller/datapath bundles for the netlist evaluator.
package gne_pkg;

  localparam int IDX_W  = 6;
  localparam int FUNC_W = 3;
  localparam int KIND_W = 3;
  localparam int STAT_W = 2;

  localparam logic [FUNC_W-1:0] FUNC_ADD      = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_SET      = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_SIM      = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_READ     = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_READ_ALL = 3'd4;

  localparam logic [KIND_W-1:0] KIND_AND  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_OR   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_NAND = 3'd2;
  localparam logic [KIND_W-1:0] KIND_NOR  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_XOR  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_XNOR = 3'd5;
  localparam logic [KIND_W-1:0] KIND_NOT  = 3'd6;
  localparam logic [KIND_W-1:0] KIND_BAD  = 3'd7;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
  localparam logic [STAT_W-1:0] ST_KIND = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [KIND_W-1:0] gate_kind;
    logic [IDX_W-1:0]  first_node;
    logic [IDX_W-1:0]  second_node;
    logic [IDX_W-1:0]  out_node;
    logic              level;
  } in_beat_t;

  typedef struct packed {
    logic [IDX_W-1:0]  node_index;
    logic              node_level;
    logic              last;
    logic [STAT_W-1:0] status;
  } out_beat_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  a;
    logic [IDX_W-1:0]  b;
    logic [IDX_W-1:0]  y;
  } gate_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;        // capture input beat
    logic add;          // add gate command
    logic set;          // set node command
    logic rd_first;     // read node command: read port A at first_node
    logic ra_clr;       // start read-all sweep
    logic ra_rd;        // read port A at sweep index
    logic ra_step;      // advance sweep index
    logic sim_clr;      // start simulate
    logic gate_rd;      // read gate table entry
    logic node_rd_gate; // read gate inputs from node store
    logic sim_eval;     // evaluate gate, write output node
    logic out_load;     // load output register
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic gc_zero;
    logic nc_zero;
    logic sim_i_last;
    logic sim_j_last;
    logic ra_last;
    logic out_free;
  } dp_stat_t;

endpackage

@@ sv/gne_if.sv @@
// Valid/ready channel interfaces for command and result beats.
interface gne_in_if;
  import gne_pkg::*;
  logic     valid;
  logic     ready;
  in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gne_out_if;
  import gne_pkg::*;
  logic      valid;
  logic      ready;
  out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ sv/gne_ctl.sv @@
// Command sequencer: accepts a beat, dispatches it and steps simulate and read-all.
module gne_ctl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  gne_pkg::dp_stat_t stat_i,
  output gne_pkg::ctl_cmd_t cmd_o
);
  import gne_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_EMIT  = 3'd2;
  localparam logic [2:0] S_RA_RD = 3'd3;
  localparam logic [2:0] S_SIM_G = 3'd4;
  localparam logic [2:0] S_SIM_N = 3'd5;
  localparam logic [2:0] S_SIM_E = 3'd6;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DISP;
        end
      end
      S_DISP: begin
        case (stat_i.func)
          FUNC_ADD: begin
            cmd_o.add = 1'b1;
            state_d   = S_EMIT;
          end
          FUNC_SET: begin
            cmd_o.set = 1'b1;
            state_d   = S_IDLE;
          end
          FUNC_SIM: begin
            cmd_o.sim_clr = 1'b1;
            state_d       = stat_i.gc_zero ? S_IDLE : S_SIM_G;
          end
          FUNC_READ: begin
            cmd_o.rd_first = 1'b1;
            state_d        = S_EMIT;
          end
          FUNC_READ_ALL: begin
            cmd_o.ra_clr = 1'b1;
            state_d      = stat_i.nc_zero ? S_IDLE : S_RA_RD;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (stat_i.func == FUNC_READ_ALL) begin
            cmd_o.ra_step = 1'b1;
            state_d       = stat_i.ra_last ? S_IDLE : S_RA_RD;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_RA_RD: begin
        cmd_o.ra_rd = 1'b1;
        state_d     = S_EMIT;
      end
      S_SIM_G: begin
        cmd_o.gate_rd = 1'b1;
        state_d       = S_SIM_N;
      end
      S_SIM_N: begin
        cmd_o.node_rd_gate = 1'b1;
        state_d            = S_SIM_E;
      end
      S_SIM_E: begin
        cmd_o.sim_eval = 1'b1;
        state_d = (stat_i.sim_i_last && stat_i.sim_j_last) ? S_IDLE : S_SIM_G;
      end
      default: state_d = S_IDLE;
    endcase
  end

  a_accept_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_DISP))
    else $error("accepted beat not dispatched");

  a_load_only_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (state_q == S_EMIT))
    else $error("output load outside emit");

endmodule

@@ sv/gne_dp.sv @@
// Datapath: gate table, node store, counters and the output register.
module gne_dp #(
  parameter int MAX_NODES = 64,
  parameter int MAX_GATES = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gne_pkg::ctl_cmd_t  cmd_i,
  output gne_pkg::dp_stat_t  stat_o,
  input  gne_pkg::in_beat_t  in_data_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output gne_pkg::out_beat_t out_data_o
);
  import gne_pkg::*;

  localparam int NW  = $clog2(MAX_NODES);
  localparam int GW  = (MAX_GATES > 1) ? $clog2(MAX_GATES) : 1;
  localparam int GCW = $clog2(MAX_GATES + 1);
  localparam int NCW = $clog2(MAX_NODES + 1);

  function automatic logic [NCW-1:0] touch(input logic [NCW-1:0] nc,
                                           input logic [IDX_W-1:0] idx,
                                           input logic en);
    logic [IDX_W:0] nxt;
    nxt = {1'b0, idx} + 1'b1;
    if (en && (int'(idx) < MAX_NODES) && (int'(nxt) > int'(nc))) begin
      return NCW'(nxt);
    end
    return nc;
  endfunction

  function automatic logic eval_gate(input logic [KIND_W-1:0] kind,
                                     input logic a, input logic b);
    case (kind)
      KIND_AND:  return a & b;
      KIND_OR:   return a | b;
      KIND_NAND: return ~(a & b);
      KIND_NOR:  return ~(a | b);
      KIND_XOR:  return a ^ b;
      KIND_XNOR: return ~(a ^ b);
      KIND_NOT:  return ~a;
      default:   return 1'b0;
    endcase
  endfunction

  in_beat_t          cmd_q;
  logic [STAT_W-1:0] add_stat_q;
  logic [GCW-1:0]    gc_q, si_q, sj_q;
  logic [NCW-1:0]    nc_q, nc_d, ra_q;
  gate_t             gate_mem [MAX_GATES];
  gate_t             gate_rd_q;
  logic              node_mem [MAX_NODES];
  logic [MAX_NODES-1:0] node_vld_q;
  logic              rd_a_q, rd_b_q, ok_a_q, ok_b_q;
  logic              out_valid_q;
  out_beat_t         out_q, out_d;

  logic              full, kind_bad, add_ok;
  logic              node_a, node_b;
  logic              re_a, re_b;
  logic [IDX_W-1:0]  addr_a, addr_b;
  logic              node_we, node_wd;
  logic [IDX_W-1:0]  node_wa;
  logic              out_free;

  assign full     = (int'(gc_q) >= MAX_GATES);
  assign kind_bad = (cmd_q.gate_kind == KIND_BAD);
  assign add_ok   = cmd_i.add && !full && !kind_bad;
  assign node_a   = rd_a_q & ok_a_q;
  assign node_b   = rd_b_q & ok_b_q;
  assign out_free = !out_valid_q || out_ready_i;

  // node store ports
  always_comb begin
    re_a    = cmd_i.rd_first || cmd_i.ra_rd || cmd_i.node_rd_gate;
    re_b    = cmd_i.node_rd_gate;
    addr_b  = gate_rd_q.b;
    if (cmd_i.rd_first) begin
      addr_a = cmd_q.first_node;
    end else if (cmd_i.ra_rd) begin
      addr_a = IDX_W'(ra_q);
    end else begin
      addr_a = gate_rd_q.a;
    end
    node_we = cmd_i.set || cmd_i.sim_eval;
    if (cmd_i.set) begin
      node_wa = cmd_q.first_node;
      node_wd = cmd_q.level;
    end else begin
      node_wa = gate_rd_q.y;
      node_wd = eval_gate(gate_rd_q.kind, node_a, node_b);
    end
  end

  // an entry never written reads as zero; out-of-range indices read zero, drop writes
  always_ff @(posedge clk_i) begin
    if (node_we && (int'(node_wa) < MAX_NODES)) begin
      node_mem[node_wa[NW-1:0]] <= node_wd;
    end
    if (re_a) begin
      rd_a_q <= node_mem[addr_a[NW-1:0]];
    end
    if (re_b) begin
      rd_b_q <= node_mem[addr_b[NW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_vld_q <= '0;
      ok_a_q     <= 1'b0;
      ok_b_q     <= 1'b0;
    end else begin
      if (node_we && (int'(node_wa) < MAX_NODES)) begin
        node_vld_q[node_wa[NW-1:0]] <= 1'b1;
      end
      if (re_a) begin
        ok_a_q <= (int'(addr_a) < MAX_NODES) && node_vld_q[addr_a[NW-1:0]];
      end
      if (re_b) begin
        ok_b_q <= (int'(addr_b) < MAX_NODES) && node_vld_q[addr_b[NW-1:0]];
      end
    end
  end

  // gate table
  always_ff @(posedge clk_i) begin
    if (add_ok) begin
      gate_mem[gc_q[GW-1:0]] <= '{kind: cmd_q.gate_kind, a: cmd_q.first_node,
                                  b: cmd_q.second_node, y: cmd_q.out_node};
    end
    if (cmd_i.gate_rd) begin
      gate_rd_q <= gate_mem[si_q[GW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cmd_q <= in_data_i;
    end
    if (cmd_i.add) begin
      add_stat_q <= full ? ST_FULL : (kind_bad ? ST_KIND : ST_OK);
    end
  end

  always_comb begin
    nc_d = nc_q;
    if (add_ok) begin
      nc_d = touch(touch(touch(nc_q, cmd_q.first_node, 1'b1), cmd_q.second_node,
                         cmd_q.gate_kind != KIND_NOT), cmd_q.out_node, 1'b1);
    end else if (cmd_i.set || cmd_i.rd_first) begin
      nc_d = touch(nc_q, cmd_q.first_node, 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gc_q <= '0;
      nc_q <= '0;
      si_q <= '0;
      sj_q <= '0;
      ra_q <= '0;
    end else begin
      nc_q <= nc_d;
      if (add_ok) begin
        gc_q <= gc_q + GCW'(1);
      end
      if (cmd_i.sim_clr) begin
        si_q <= '0;
        sj_q <= '0;
      end else if (cmd_i.sim_eval) begin
        if (stat_o.sim_i_last) begin
          si_q <= '0;
          sj_q <= sj_q + GCW'(1);
        end else begin
          si_q <= si_q + GCW'(1);
        end
      end
      if (cmd_i.ra_clr) begin
        ra_q <= '0;
      end else if (cmd_i.ra_step) begin
        ra_q <= ra_q + NCW'(1);
      end
    end
  end

  // output register
  always_comb begin
    case (cmd_q.func)
      FUNC_ADD: out_d = '{node_index: cmd_q.out_node, node_level: 1'b0,
                          last: 1'b1, status: add_stat_q};
      FUNC_READ: out_d = '{node_index: cmd_q.first_node, node_level: node_a,
                           last: 1'b1, status: ST_OK};
      default: out_d = '{node_index: IDX_W'(ra_q), node_level: node_a,
                         last: stat_o.ra_last, status: ST_OK};
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    stat_o            = '0;
    stat_o.func       = cmd_q.func;
    stat_o.gc_zero    = (gc_q == '0);
    stat_o.nc_zero    = (nc_q == '0);
    stat_o.sim_i_last = ((si_q + GCW'(1)) == gc_q);
    stat_o.sim_j_last = ((sj_q + GCW'(1)) == gc_q);
    stat_o.ra_last    = ((ra_q + NCW'(1)) == nc_q);
    stat_o.out_free   = out_free;
  end

  a_gc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(gc_q) <= MAX_GATES)
    else $error("gate count beyond table");

  a_nc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(nc_q) <= MAX_NODES)
    else $error("node count beyond node store");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> out_free)
    else $error("pending result overwritten");

endmodule

@@ sv/gate_netlist_evaluator.sv @@
// Top level of the two-input gate netlist evaluator.
// One command beat is taken at a time; in_i is ready only while no command is in
// progress, but a finished result may still sit in the output register. Add
// gate, read node and each node of read all wait for a free output register;
// simulate makes gc passes over its gc gates, and every gate evaluation is a
// gate table read, a node store read of both inputs, and a write-back in turn,
// and the next evaluation must see that write.
module gate_netlist_evaluator #(
  parameter int MAX_NODES = 64,
  parameter int MAX_GATES = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  gne_in_if.sink    in_i,
  gne_out_if.source out_o
);
  import gne_pkg::*;

  ctl_cmd_t  cmd;
  dp_stat_t  stat;
  logic      in_ready;
  logic      out_valid;
  out_beat_t out_data;

  gne_ctl u_ctl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  gne_dp #(
    .MAX_NODES (MAX_NODES),
    .MAX_GATES (MAX_GATES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (in_i.data),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_valid),
    .out_data_o  (out_data)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;
  assign out_o.data  = out_data;

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the gate netlist evaluator: predictor, driver, monitor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gne_pkg::*;

  localparam int NODES        = 64;
  localparam int GATES        = 64;
  localparam int CLK_PERIOD   = 20;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int RAND_CMDS    = 220;
  localparam int GATE_CAP     = 32;   // keeps simulate short during the random part
  localparam int IDLE_PCT     = 38;
  localparam int HOLD_CYCLES  = 400;
  localparam int FUNC_CODES   = 1 << FUNC_W;
  localparam int MAX_PRINTS   = 100;

  localparam logic [IDX_W-1:0] TOP_NODE = IDX_W'(NODES - 1);

  logic clk_i;
  logic rst_ni;

  gne_in_if  cmd_if ();
  gne_out_if res_if ();

  gate_netlist_evaluator #(
    .MAX_NODES(NODES),
    .MAX_GATES(GATES)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cmd_if),
    .out_o (res_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Netlist predictor state
  // ---------------------------------------------------------------------------
  bit          node_lv  [NODES];
  gate_t       gate_tab [GATES];
  int unsigned gate_cnt;
  int unsigned used_cnt;
  out_beat_t   want_results [$];

  in_beat_t    cmd_queue [$];
  int unsigned planned_gates;
  int unsigned stim_count;
  int unsigned cmds_accepted;
  int unsigned results_seen;
  int unsigned bad_count;
  logic        cmd_took;
  logic        calm;
  int unsigned hold_left;
  bit          hold_done;

  // no random idling on either side inside this window
  assign calm = (cmds_accepted >= 150) && (cmds_accepted < 200);

  function automatic logic gate_out(logic [KIND_W-1:0] k, logic a, logic b);
    case (k)
      KIND_AND:  return a & b;
      KIND_OR:   return a | b;
      KIND_NAND: return ~(a & b);
      KIND_NOR:  return ~(a | b);
      KIND_XOR:  return a ^ b;
      KIND_XNOR: return ~(a ^ b);
      KIND_NOT:  return ~a;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic void mark_used(int unsigned idx);
    if (idx < NODES && idx + 1 > used_cnt) used_cnt = idx + 1;
  endfunction

  function automatic void eval_netlist_cmd(in_beat_t c);
    out_beat_t   r;
    int unsigned p, g;
    r      = '0;
    r.last = 1'b1;
    case (c.func)
      FUNC_ADD: begin
        r.node_index = c.out_node;
        // full table wins over a bad kind
        if (gate_cnt >= GATES) begin
          r.status = ST_FULL;
        end else if (c.gate_kind == KIND_BAD) begin
          r.status = ST_KIND;
        end else begin
          gate_tab[gate_cnt].kind = c.gate_kind;
          gate_tab[gate_cnt].a    = c.first_node;
          gate_tab[gate_cnt].b    = c.second_node;
          gate_tab[gate_cnt].y    = c.out_node;
          gate_cnt++;
          mark_used(c.first_node);
          if (c.gate_kind != KIND_NOT) mark_used(c.second_node);
          mark_used(c.out_node);
          r.status = ST_OK;
        end
        want_results = {want_results, r};
      end
      FUNC_SET: begin
        node_lv[c.first_node] = c.level;
        mark_used(c.first_node);
      end
      FUNC_SIM: begin
        // gates write back immediately; later gates in a pass see new values
        for (p = 0; p < gate_cnt; p++) begin
          for (g = 0; g < gate_cnt; g++) begin
            node_lv[gate_tab[g].y] = gate_out(gate_tab[g].kind, node_lv[gate_tab[g].a],
                                              node_lv[gate_tab[g].b]);
          end
        end
      end
      FUNC_READ: begin
        mark_used(c.first_node);
        r.node_index = c.first_node;
        r.node_level = node_lv[c.first_node];
        want_results = {want_results, r};
      end
      FUNC_READ_ALL: begin
        for (p = 0; p < used_cnt; p++) begin
          r.node_index = p[IDX_W-1:0];
          r.node_level = node_lv[p];
          r.last       = (p + 1 == used_cnt);
          want_results = {want_results, r};
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    bad_count++;
    if (bad_count <= MAX_PRINTS) $display("MISMATCH at %0t ns: %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void queue_cmd(logic [FUNC_W-1:0] f, logic [KIND_W-1:0] k,
                                    logic [IDX_W-1:0] a, logic [IDX_W-1:0] b,
                                    logic [IDX_W-1:0] y, logic l);
    in_beat_t c;
    c.func        = f;
    c.gate_kind   = k;
    c.first_node  = a;
    c.second_node = b;
    c.out_node    = y;
    c.level       = l;
    cmd_queue = {cmd_queue, c};
    if (f <= FUNC_READ_ALL) stim_count++;
    if (f == FUNC_ADD && k != KIND_BAD && planned_gates < GATES) planned_gates++;
  endfunction

  function automatic logic [IDX_W-1:0] any_node();
    return IDX_W'($urandom_range(NODES - 1));
  endfunction

  function automatic logic [KIND_W-1:0] good_kind();
    return KIND_W'($urandom_range(KIND_NOT));
  endfunction

  function automatic void queue_random_gate();
    queue_cmd(FUNC_ADD, good_kind(), any_node(), any_node(), any_node(),
              1'($urandom_range(1)));
  endfunction

  // fully random beat; adds past the cap turn into reads
  function automatic void queue_noise();
    logic [FUNC_W-1:0] f;
    logic [KIND_W-1:0] k;
    f = FUNC_W'($urandom_range(FUNC_CODES - 1));
    k = KIND_W'($urandom_range(KIND_BAD));
    if (f == FUNC_ADD && k != KIND_BAD && planned_gates >= GATE_CAP) f = FUNC_READ;
    queue_cmd(f, k, any_node(), any_node(), any_node(), 1'($urandom_range(1)));
  endfunction

  // ---------------------------------------------------------------------------
  // Command driver: beats change on the falling edge
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_took <= 1'b0;
    end else begin
      cmd_took <= cmd_if.valid && cmd_if.ready;
      if (cmd_if.valid && cmd_if.ready) begin
        eval_netlist_cmd(cmd_if.data);
        cmds_accepted++;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      cmd_if.valid <= 1'b0;
    end else if (cmd_if.valid && !cmd_took) begin
      // beat still waiting for ready: hold it
    end else if (cmd_queue.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
      cmd_if.data  <= cmd_queue.pop_front();
      cmd_if.valid <= 1'b1;
    end else begin
      cmd_if.valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: ready with random stalls and one long hold-off
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      res_if.ready <= 1'b0;
    end else if (!hold_done && results_seen >= 40) begin
      hold_done    <= 1'b1;
      hold_left    <= HOLD_CYCLES;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin : check_results
    out_beat_t exp_r;
    if (rst_ni && res_if.valid && res_if.ready) begin
      results_seen++;
      if (want_results.size() == 0) begin
        report_mismatch($sformatf("result for node %0d with nothing pending",
                                  res_if.data.node_index));
      end else begin
        exp_r = want_results.pop_front();
        if (res_if.data.node_index !== exp_r.node_index)
          report_mismatch($sformatf("node_index got %0d want %0d",
                                    res_if.data.node_index, exp_r.node_index));
        if (res_if.data.node_level !== exp_r.node_level)
          report_mismatch($sformatf("node_level of node %0d got %b want %b",
                                    exp_r.node_index, res_if.data.node_level,
                                    exp_r.node_level));
        if (res_if.data.last !== exp_r.last)
          report_mismatch($sformatf("last of node %0d got %b want %b",
                                    exp_r.node_index, res_if.data.last, exp_r.last));
        if (res_if.data.status !== exp_r.status)
          report_mismatch($sformatf("status of node %0d got %0d want %0d",
                                    exp_r.node_index, res_if.data.status, exp_r.status));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned f, k, n, r;
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cmd_if.valid  = 1'b0;
    cmd_if.data   = '0;
    res_if.ready  = 1'b0;
    gate_cnt      = 0;
    used_cnt      = 0;
    planned_gates = 0;
    stim_count    = 0;
    cmds_accepted = 0;
    results_seen  = 0;
    bad_count     = 0;
    hold_left     = 0;
    hold_done     = 1'b0;
    foreach (node_lv[i]) node_lv[i] = 1'b0;

    // directed: empty read-all, unused codes, NOT ignoring its second input
    queue_cmd(FUNC_READ_ALL, KIND_AND, 0, 0, 0, 0);
    for (f = FUNC_READ_ALL + 1; f < FUNC_CODES; f++)
      queue_cmd(FUNC_W'(f), KIND_W'($urandom_range(KIND_BAD)), any_node(), any_node(),
                any_node(), 1);
    queue_cmd(FUNC_ADD, KIND_NOT, 0, TOP_NODE, 1, 0);
    queue_cmd(FUNC_READ_ALL, KIND_AND, 0, 0, 0, 0);
    queue_cmd(FUNC_SET, KIND_AND, 0, 0, 0, 1);
    queue_cmd(FUNC_SIM, KIND_AND, 0, 0, 0, 0);
    queue_cmd(FUNC_READ, KIND_AND, 1, 0, 0, 0);
    queue_cmd(FUNC_ADD, KIND_BAD, TOP_NODE, TOP_NODE, TOP_NODE, 1);
    for (k = KIND_AND; k <= KIND_XNOR; k++)
      queue_cmd(FUNC_ADD, KIND_W'(k), k[0] ? TOP_NODE : IDX_W'(0),
                k[1] ? IDX_W'(0) : TOP_NODE, IDX_W'(62 - k), 0);
    queue_cmd(FUNC_SET, KIND_AND, TOP_NODE, 0, 0, 1);
    queue_cmd(FUNC_SET, KIND_AND, 0, 0, 0, 0);
    queue_cmd(FUNC_SIM, KIND_AND, 0, 0, 0, 0);
    queue_cmd(FUNC_READ_ALL, KIND_AND, 0, 0, 0, 0);
    queue_cmd(FUNC_SET, KIND_AND, 0, TOP_NODE, TOP_NODE, 1);
    queue_cmd(FUNC_SIM, KIND_AND, 0, 0, 0, 0);
    queue_cmd(FUNC_READ, KIND_AND, 62, 0, 0, 0);
    queue_cmd(FUNC_READ, KIND_AND, TOP_NODE, 0, 0, 1);

    // random: mostly build/drive/simulate/read episodes, some noise
    stim_count = 0;
    while (stim_count < RAND_CMDS) begin
      r = $urandom_range(99);
      if (r < 15) begin
        queue_noise();
      end else if (r < 25) begin
        // broken flow: bad or extra gates, then read back without simulating
        n = $urandom_range(1, 3);
        repeat (n) begin
          if (planned_gates < GATE_CAP && $urandom_range(1))
            queue_random_gate();
          else
            queue_cmd(FUNC_ADD, KIND_BAD, any_node(), any_node(), any_node(), 0);
        end
        queue_cmd(FUNC_READ_ALL, KIND_AND, any_node(), 0, 0, 0);
      end else begin
        n = $urandom_range(0, 3);
        repeat (n) if (planned_gates < GATE_CAP) queue_random_gate();
        n = $urandom_range(1, 4);
        repeat (n) queue_cmd(FUNC_SET, good_kind(), any_node(), any_node(), any_node(),
                             1'($urandom_range(1)));
        queue_cmd(FUNC_SIM, good_kind(), any_node(), any_node(), any_node(), 0);
        n = $urandom_range(1, 3);
        repeat (n) queue_cmd(FUNC_READ, good_kind(), any_node(), any_node(), any_node(),
                             1'($urandom_range(1)));
        if ($urandom_range(2) == 0) queue_cmd(FUNC_READ_ALL, KIND_AND, 0, 0, 0, 0);
      end
    end

    // fill the table, then hit the full case, bad kind included
    while (planned_gates < GATES) queue_random_gate();
    queue_cmd(FUNC_ADD, good_kind(), any_node(), any_node(), any_node(), 0);
    queue_cmd(FUNC_ADD, KIND_BAD, any_node(), any_node(), any_node(), 1);
    queue_cmd(FUNC_SET, KIND_AND, any_node(), 0, 0, 1);
    queue_cmd(FUNC_SIM, KIND_AND, 0, 0, 0, 0);
    queue_cmd(FUNC_READ_ALL, KIND_AND, 0, 0, 0, 0);
    queue_cmd(FUNC_SIM, KIND_AND, 0, 0, 0, 0);

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (cmd_queue.size() != 0 || cmd_if.valid || want_results.size() != 0)
      @(posedge clk_i);
    // a trailing simulate may still be running
    repeat (3 * gate_cnt * gate_cnt + 20) @(posedge clk_i);

    if (bad_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
